// ----- sv/rtsd_pkg.sv -----
// Shared types, constants and helpers of the reference-tracking supply duty block.
// Used by rtsd_div, rtsd_mul and reference_tracking_supply_duty; depends on nothing.
`timescale 1ns / 1ps

package rtsd_pkg;

  localparam int AdcW     = 16;
  localparam int AvgDepth = 8;
  localparam int SlotW    = $clog2(AvgDepth);
  localparam int SumW     = AdcW + SlotW;
  localparam int MvW      = 13;
  localparam int DutyW    = 7;
  localparam int CmpW     = 20;
  localparam int DacW     = 12;
  localparam int V20W     = 18;
  localparam int DacSW    = 15;
  localparam int OutW     = 48;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 20;

  localparam int NumW     = 29;
  localparam int DenW     = 16;
  localparam int DivCntW  = 5;
  localparam int MulW     = 29;
  localparam int MplW     = 13;
  localparam int MulCntW  = 4;

  localparam int MvProdW  = AdcW + MplW;
  localparam int CmpProdW = CmpW + DutyW;

  localparam logic [CfgIdxW-1:0] CfgDefaultVoltage = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgDefaultPower   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgDefaultPort    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgBoardFormula   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgPwmReload      = 3'd4;

  localparam logic [1:0] FormulaLow    = 2'd0;
  localparam logic [1:0] FormulaHigh   = 2'd1;
  localparam logic [1:0] FormulaScaled = 2'd2;

  localparam logic [MplW-1:0]  MvScale       = 13'd6600;
  localparam logic [DenW-1:0]  AdcFull       = 16'd65535;
  localparam logic [MvW-1:0]   PresentMv     = 13'd1600;
  localparam logic [DenW-1:0]  ScaledDen     = 16'd47;
  localparam logic [DenW-1:0]  DutyDen       = 16'd33;
  localparam logic [DenW-1:0]  PercentDen    = 16'd100;
  localparam logic [DutyW-1:0] DutyMax       = 7'd100;
  localparam logic signed [DacSW-1:0] OffsetLow    = 15'sd4997;
  localparam logic signed [DacSW-1:0] OffsetHigh   = 15'sd6314;
  localparam logic signed [DacSW-1:0] OffsetScaled = 15'sd3391;
  localparam logic signed [DacSW-1:0] DacMax       = 15'sd3300;

  localparam logic [MvW-1:0]  ResetVoltage = 13'd3300;
  localparam logic [CmpW-1:0] ResetReload  = 20'd2000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_AVG,
    S_MV_MUL,
    S_MV_DIV,
    S_V_DIV,
    S_DUTY_DIV,
    S_CMP_MUL,
    S_CMP_DIV,
    S_OUT
  } rtsd_state_t;

  typedef struct packed {
    logic               start;
    logic [NumW-1:0]    num;
    logic [DenW-1:0]    den;
    logic [DivCntW-1:0] steps;
  } rtsd_div_req_t;

  typedef struct packed {
    logic               start;
    logic [MulW-1:0]    mcand;
    logic [MplW-1:0]    mplier;
    logic [MulCntW-1:0] steps;
  } rtsd_mul_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rtsd_unit_sts_t;

  function automatic logic [DacW-1:0] dac_clamp(input logic signed [DacSW-1:0] d);
    logic [DacW-1:0] r;
    if (d < 0) begin
      r = '0;
    end else if (d > DacMax) begin
      r = DacMax[DacW-1:0];
    end else begin
      r = d[DacW-1:0];
    end
    return r;
  endfunction

endpackage

// ----- sv/rtsd_div.sv -----
// Bit-serial restoring divider shared by every division of the block.
// Depends on rtsd_pkg for its request and status types.
`timescale 1ns / 1ps

module rtsd_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rtsd_pkg::rtsd_div_req_t             req,
  output rtsd_pkg::rtsd_unit_sts_t            sts,
  output logic [rtsd_pkg::NumW-1:0]           quo
);

  logic                              busy_r;
  logic                              done_r;
  logic [rtsd_pkg::DivCntW-1:0]      cnt_r;
  logic [rtsd_pkg::DenW-1:0]         rem_r;
  logic [rtsd_pkg::DenW-1:0]         rem_nxt;
  logic [rtsd_pkg::NumW-1:0]         quo_r;
  logic [rtsd_pkg::NumW-1:0]         quo_nxt;
  logic [rtsd_pkg::DenW-1:0]         den_r;
  logic [rtsd_pkg::DenW:0]           trial;
  logic [rtsd_pkg::DenW:0]           diff;
  logic                              fits;
  logic                              last;

  assign last  = busy_r && (cnt_r == '0);
  assign trial = {rem_r, quo_r[rtsd_pkg::NumW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = trial >= {1'b0, den_r};

  always_comb begin
    rem_nxt = fits ? diff[rtsd_pkg::DenW-1:0] : trial[rtsd_pkg::DenW-1:0];
    quo_nxt = {quo_r[rtsd_pkg::NumW-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= last;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps - 1'b1;
      end else if (last) begin
        busy_r <= 1'b0;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.num;
      den_r <= req.den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quo      = quo_r;

`ifndef SYNTHESIS
  ap_div_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("Divider started while a division is still running.");
`endif

endmodule

// ----- sv/rtsd_mul.sv -----
// Bit-serial shift-and-add multiplier shared by both products of the block.
// Depends on rtsd_pkg for its request and status types.
`timescale 1ns / 1ps

module rtsd_mul (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rtsd_pkg::rtsd_mul_req_t             req,
  output rtsd_pkg::rtsd_unit_sts_t            sts,
  output logic [rtsd_pkg::MulW-1:0]           prod
);

  logic                              busy_r;
  logic                              done_r;
  logic [rtsd_pkg::MulCntW-1:0]      cnt_r;
  logic [rtsd_pkg::MulW-1:0]         acc_r;
  logic [rtsd_pkg::MulW-1:0]         acc_nxt;
  logic [rtsd_pkg::MulW-1:0]         mcand_r;
  logic [rtsd_pkg::MplW-1:0]         mpl_r;
  logic                              last;

  assign last = busy_r && (cnt_r == '0);

  always_comb begin
    acc_nxt = mpl_r[0] ? acc_r + mcand_r : acc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= last;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps - 1'b1;
      end else if (last) begin
        busy_r <= 1'b0;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc_r   <= '0;
      mcand_r <= req.mcand;
      mpl_r   <= req.mplier;
    end else if (busy_r) begin
      acc_r   <= acc_nxt;
      mcand_r <= {mcand_r[rtsd_pkg::MulW-2:0], 1'b0};
      mpl_r   <= {1'b0, mpl_r[rtsd_pkg::MplW-1:1]};
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign prod     = acc_r;

`ifndef SYNTHESIS
  ap_mul_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("Multiplier started while a product is still running.");
`endif

endmodule

// ----- sv/reference_tracking_supply_duty.sv -----
// Top level of the reference-tracking supply duty block: averaging ring, sequencer,
// configuration registers and result register. Depends on rtsd_pkg, rtsd_div, rtsd_mul.
`timescale 1ns / 1ps

// Usage:
// Each transfer on the in_ channel carries one raw 16-bit reference sample. The block
// keeps an eight-sample moving average, converts it to millivolts and decides whether
// the external reference is present. It then picks the tracked or default voltage,
// maps it through the selected board formula, and produces one result transfer on the
// out_ channel with the PWM compare count, duty, averaged millivolts and enable levels.
// Registers are written through cfg_we, cfg_index and cfg_wdata; the user must write
// them only while the block is idle, which the block itself does not enforce. The time
// an item takes is set by the shared divider and multiplier, which resolve one bit per
// cycle; the scaled board formula adds one division. in_tready returns in the cycle in
// which out_tvalid rises, so one item is in work at a time and a new transfer is taken
// only after the last result has been loaded into the output register.
// Reset (synchronous, active low) clears the sample ring, the running sum and the
// slot, and loads the register defaults. A stalled receiver holds the result in the
// output register; the next sample may still be taken and worked on, and its result
// waits until the output register is free.
module reference_tracking_supply_duty (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [15:0]                      in_tdata,   // [15:0] adc_sample
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [19:0] compare_value, [26:20] duty_percent, [39:27] ref_mv, [40] ref_present,
  // [41] power_enable, [42] port_enable, [47:43] zero
  output logic [rtsd_pkg::OutW-1:0]        out_tdata,
  input  logic                             cfg_we,
  input  logic [rtsd_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [rtsd_pkg::CfgDataW-1:0]    cfg_wdata
);

  rtsd_pkg::rtsd_state_t             state_r;
  rtsd_pkg::rtsd_state_t             state_nxt;

  logic [rtsd_pkg::AdcW-1:0]         ring_r [rtsd_pkg::AvgDepth];
  logic [rtsd_pkg::SlotW-1:0]        slot_r;
  logic [rtsd_pkg::SlotW-1:0]        slot_nxt;
  logic [rtsd_pkg::SumW-1:0]         sum_r;
  logic [rtsd_pkg::SumW-1:0]         sum_nxt;

  logic [rtsd_pkg::MvW-1:0]          def_mv_r;
  logic                              def_pwr_r;
  logic                              def_port_r;
  logic [1:0]                        formula_r;
  logic [rtsd_pkg::CmpW-1:0]         reload_r;

  logic [rtsd_pkg::MvW-1:0]          mv_r;
  logic                              present_r;
  logic                              pwr_r;
  logic                              port_r;
  logic [rtsd_pkg::DutyW-1:0]        duty_r;
  logic [rtsd_pkg::CmpW-1:0]         cmp_r;
  logic                              out_tvalid_r;
  logic [rtsd_pkg::OutW-1:0]         out_tdata_r;

  rtsd_pkg::rtsd_div_req_t           div_req;
  rtsd_pkg::rtsd_unit_sts_t          div_sts;
  logic [rtsd_pkg::NumW-1:0]         div_quo;
  rtsd_pkg::rtsd_mul_req_t           mul_req;
  rtsd_pkg::rtsd_unit_sts_t          mul_sts;
  logic [rtsd_pkg::MulW-1:0]         mul_prod;

  logic                              accept;
  logic                              out_load;
  logic                              mv_take;
  logic                              duty_take;
  logic                              cmp_take;
  logic [rtsd_pkg::MvW-1:0]          mv_c;
  logic                              present_c;
  logic [rtsd_pkg::MvW-1:0]          v_c;
  logic [rtsd_pkg::V20W-1:0]         v20_c;
  logic signed [rtsd_pkg::DacSW-1:0] dac_direct_s;
  logic signed [rtsd_pkg::DacSW-1:0] dac_scaled_s;
  logic [rtsd_pkg::DacW-1:0]         dac_c;
  logic [rtsd_pkg::CmpW-1:0]         cmp_q;
  logic [rtsd_pkg::CmpW-1:0]         cmp_c;

  rtsd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .sts   (div_sts),
    .quo   (div_quo)
  );

  rtsd_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .sts   (mul_sts),
    .prod  (mul_prod)
  );

  assign accept   = in_tvalid && in_tready;
  assign out_load = (state_r == rtsd_pkg::S_OUT) && (!out_tvalid_r || out_tready);

  assign sum_nxt  = sum_r - rtsd_pkg::SumW'(ring_r[slot_r])
                    + rtsd_pkg::SumW'(in_tdata);
  assign slot_nxt = (slot_r == rtsd_pkg::SlotW'(rtsd_pkg::AvgDepth - 1))
                    ? '0 : slot_r + 1'b1;

  always_comb begin
    mv_c         = div_quo[rtsd_pkg::MvW-1:0];
    present_c    = mv_c > rtsd_pkg::PresentMv;
    v_c          = present_c ? mv_c : def_mv_r;
    v20_c        = {1'b0, v_c, 4'b0000} + {3'b000, v_c, 2'b00};
    dac_scaled_s = rtsd_pkg::OffsetScaled
                   - $signed({3'b000, div_quo[rtsd_pkg::DacW-1:0]});
    unique case (formula_r)
      rtsd_pkg::FormulaHigh: dac_direct_s = rtsd_pkg::OffsetHigh - $signed({2'b00, v_c});
      default:               dac_direct_s = rtsd_pkg::OffsetLow - $signed({2'b00, v_c});
    endcase
    dac_c = (state_r == rtsd_pkg::S_V_DIV) ? rtsd_pkg::dac_clamp(dac_scaled_s)
                                           : rtsd_pkg::dac_clamp(dac_direct_s);
    cmp_q = div_quo[rtsd_pkg::CmpW-1:0];
    cmp_c = (&cmp_q) ? cmp_q : cmp_q + 1'b1;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rtsd_pkg::S_IDLE:     if (accept) state_nxt = rtsd_pkg::S_AVG;
      rtsd_pkg::S_AVG:      if (div_sts.done) state_nxt = rtsd_pkg::S_MV_MUL;
      rtsd_pkg::S_MV_MUL:   if (mul_sts.done) state_nxt = rtsd_pkg::S_MV_DIV;
      rtsd_pkg::S_MV_DIV: begin
        if (div_sts.done) begin
          state_nxt = (formula_r == rtsd_pkg::FormulaScaled) ? rtsd_pkg::S_V_DIV
                                                             : rtsd_pkg::S_DUTY_DIV;
        end
      end
      rtsd_pkg::S_V_DIV:    if (div_sts.done) state_nxt = rtsd_pkg::S_DUTY_DIV;
      rtsd_pkg::S_DUTY_DIV: if (div_sts.done) state_nxt = rtsd_pkg::S_CMP_MUL;
      rtsd_pkg::S_CMP_MUL:  if (mul_sts.done) state_nxt = rtsd_pkg::S_CMP_DIV;
      rtsd_pkg::S_CMP_DIV:  if (div_sts.done) state_nxt = rtsd_pkg::S_OUT;
      rtsd_pkg::S_OUT:      if (out_load) state_nxt = rtsd_pkg::S_IDLE;
      default:              state_nxt = rtsd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    mv_take   = 1'b0;
    duty_take = 1'b0;
    cmp_take  = 1'b0;
    div_req   = '0;
    mul_req   = '0;
    unique case (state_r)
      rtsd_pkg::S_IDLE: begin
        in_tready     = 1'b1;
        div_req.start = accept;
        div_req.num   = rtsd_pkg::NumW'(sum_nxt) << (rtsd_pkg::NumW - rtsd_pkg::SumW);
        div_req.den   = rtsd_pkg::DenW'(rtsd_pkg::AvgDepth);
        div_req.steps = rtsd_pkg::DivCntW'(rtsd_pkg::SumW);
      end
      rtsd_pkg::S_AVG: begin
        mul_req.start  = div_sts.done;
        mul_req.mcand  = rtsd_pkg::MulW'(div_quo[rtsd_pkg::AdcW-1:0]);
        mul_req.mplier = rtsd_pkg::MvScale;
        mul_req.steps  = rtsd_pkg::MulCntW'(rtsd_pkg::MplW);
      end
      rtsd_pkg::S_MV_MUL: begin
        div_req.start = mul_sts.done;
        div_req.num   = mul_prod << (rtsd_pkg::NumW - rtsd_pkg::MvProdW);
        div_req.den   = rtsd_pkg::AdcFull;
        div_req.steps = rtsd_pkg::DivCntW'(rtsd_pkg::MvProdW);
      end
      rtsd_pkg::S_MV_DIV: begin
        mv_take       = div_sts.done;
        div_req.start = div_sts.done;
        if (formula_r == rtsd_pkg::FormulaScaled) begin
          div_req.num   = rtsd_pkg::NumW'(v20_c) << (rtsd_pkg::NumW - rtsd_pkg::V20W);
          div_req.den   = rtsd_pkg::ScaledDen;
          div_req.steps = rtsd_pkg::DivCntW'(rtsd_pkg::V20W);
        end else begin
          div_req.num   = rtsd_pkg::NumW'(dac_c) << (rtsd_pkg::NumW - rtsd_pkg::DacW);
          div_req.den   = rtsd_pkg::DutyDen;
          div_req.steps = rtsd_pkg::DivCntW'(rtsd_pkg::DacW);
        end
      end
      rtsd_pkg::S_V_DIV: begin
        div_req.start = div_sts.done;
        div_req.num   = rtsd_pkg::NumW'(dac_c) << (rtsd_pkg::NumW - rtsd_pkg::DacW);
        div_req.den   = rtsd_pkg::DutyDen;
        div_req.steps = rtsd_pkg::DivCntW'(rtsd_pkg::DacW);
      end
      rtsd_pkg::S_DUTY_DIV: begin
        duty_take      = div_sts.done;
        mul_req.start  = div_sts.done;
        mul_req.mcand  = rtsd_pkg::MulW'(reload_r);
        mul_req.mplier = rtsd_pkg::MplW'(div_quo[rtsd_pkg::DutyW-1:0]);
        mul_req.steps  = rtsd_pkg::MulCntW'(rtsd_pkg::DutyW);
      end
      rtsd_pkg::S_CMP_MUL: begin
        div_req.start = mul_sts.done;
        div_req.num   = mul_prod << (rtsd_pkg::NumW - rtsd_pkg::CmpProdW);
        div_req.den   = rtsd_pkg::PercentDen;
        div_req.steps = rtsd_pkg::DivCntW'(rtsd_pkg::CmpProdW);
      end
      rtsd_pkg::S_CMP_DIV: begin
        cmp_take = div_sts.done;
      end
      rtsd_pkg::S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= rtsd_pkg::S_IDLE;
      slot_r       <= '0;
      sum_r        <= '0;
      out_tvalid_r <= 1'b0;
      def_mv_r     <= rtsd_pkg::ResetVoltage;
      def_pwr_r    <= 1'b0;
      def_port_r   <= 1'b0;
      formula_r    <= rtsd_pkg::FormulaLow;
      reload_r     <= rtsd_pkg::ResetReload;
      for (int i = 0; i < rtsd_pkg::AvgDepth; i++) begin
        ring_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        ring_r[slot_r] <= in_tdata;
        sum_r          <= sum_nxt;
        slot_r         <= slot_nxt;
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          rtsd_pkg::CfgDefaultVoltage: def_mv_r   <= cfg_wdata[rtsd_pkg::MvW-1:0];
          rtsd_pkg::CfgDefaultPower:   def_pwr_r  <= cfg_wdata[0];
          rtsd_pkg::CfgDefaultPort:    def_port_r <= cfg_wdata[0];
          rtsd_pkg::CfgBoardFormula:   formula_r  <= cfg_wdata[1:0];
          rtsd_pkg::CfgPwmReload:      reload_r   <= cfg_wdata[rtsd_pkg::CmpW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mv_take) begin
      mv_r      <= mv_c;
      present_r <= present_c;
      pwr_r     <= present_c | def_pwr_r;
      port_r    <= present_c | def_port_r;
    end
    if (duty_take) begin
      duty_r <= div_quo[rtsd_pkg::DutyW-1:0];
    end
    if (cmp_take) begin
      cmp_r <= cmp_c;
    end
    if (out_load) begin
      out_tdata_r <= {5'b00000, port_r, pwr_r, present_r, mv_r, duty_r, cmp_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef SYNTHESIS
  ap_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> (out_tdata_r[26:20] <= rtsd_pkg::DutyMax))
    else $error("Duty above one hundred percent on the result.");

  ap_present_enables: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_tdata_r[40]) |-> (out_tdata_r[41] && out_tdata_r[42]))
    else $error("Reference present but an enable is low.");

  ap_compare_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> (out_tdata_r[19:0] != '0))
    else $error("Compare count of zero on the result.");

  ap_idle_units: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rtsd_pkg::S_IDLE) |-> (!div_sts.busy && !mul_sts.busy))
    else $error("Arithmetic unit busy while the block is idle.");
`endif

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for reference_tracking_supply_duty: streams ADC samples under
// several register settings and checks every result against an in-bench duty predictor.
// Depends on rtsd_pkg and the block's RTL only.
`timescale 1ns / 1ps

module testbench;

  localparam int ClkPeriod     = 12;
  localparam int ResetCycles   = 6;
  localparam int RandomPhases  = 8;
  localparam int PhaseSamples  = 225;
  localparam int HoldCycles    = 600;
  localparam int TailCycles    = 200;
  localparam int CycleLimit    = 1500000;
  localparam int MaxReports    = 40;

  localparam int FullScaleMv   = 6600;
  localparam int AdcMax        = 65535;
  localparam int PresenceMv    = 1600;
  localparam int PresentAvg    = 15898;
  localparam int LowOffset     = 4997;
  localparam int HighOffset    = 6314;
  localparam int ScaledOffset  = 3391;
  localparam int ScaledMul     = 20;
  localparam int ScaledDiv     = 47;
  localparam int DacCeiling    = 3300;
  localparam int MvPerPercent  = 33;
  localparam int VoltageTop    = 5000;
  localparam int VoltageMax    = 8191;
  localparam int ReloadTop     = 1000000;
  localparam longint unsigned CompareMax = 64'hFFFFF;

  localparam logic [1:0] FormulaSpare = 2'd3;

  typedef struct {
    logic [19:0] compare_value;
    logic [6:0]  duty_percent;
    logic [12:0] ref_mv;
    logic        ref_present;
    logic        power_enable;
    logic        port_enable;
  } supply_result_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_tvalid = 1'b0;
  logic                          in_tready;
  logic [15:0]                   in_tdata = '0;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [rtsd_pkg::OutW-1:0]     out_tdata;
  logic                          cfg_we = 1'b0;
  logic [rtsd_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [rtsd_pkg::CfgDataW-1:0] cfg_wdata = '0;

  logic [15:0]    pending_samples[$];
  supply_result_t expected_results[$];

  logic [15:0] ring_samples[rtsd_pkg::AvgDepth] = '{default: '0};
  logic [18:0] ring_sum = '0;
  logic [2:0]  ring_pos = '0;

  logic [12:0] default_voltage = 13'd3300;
  logic        default_power = 1'b0;
  logic        default_port = 1'b0;
  logic [1:0]  formula_sel = 2'd0;
  logic [19:0] pwm_reload = 20'd2000;

  int unsigned src_idle_pct = 15;
  int unsigned sink_idle_pct = 15;
  logic        hold_arm = 1'b0;
  logic        hold_started = 1'b0;
  int unsigned hold_left = 0;
  int unsigned mismatch_count = 0;
  int unsigned result_count = 0;
  int unsigned cycle_count = 0;

  reference_tracking_supply_duty u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  function automatic supply_result_t track_sample(input logic [15:0] sample);
    supply_result_t  r;
    int unsigned     avg;
    int unsigned     mv;
    int              v;
    int              dac;
    int unsigned     duty;
    longint unsigned cmp;
    ring_sum = ring_sum - ring_samples[ring_pos] + sample;
    ring_samples[ring_pos] = sample;
    ring_pos = ring_pos + 3'd1;
    avg = ring_sum / rtsd_pkg::AvgDepth;
    mv = (avg * FullScaleMv) / AdcMax;
    r.ref_mv = mv[12:0];
    r.ref_present = (mv > PresenceMv);
    if (r.ref_present) begin
      v = int'(mv);
      r.power_enable = 1'b1;
      r.port_enable = 1'b1;
    end else begin
      v = int'(default_voltage);
      r.power_enable = default_power;
      r.port_enable = default_port;
    end
    case (formula_sel)
      rtsd_pkg::FormulaHigh: begin
        dac = HighOffset - v;
      end
      rtsd_pkg::FormulaScaled: begin
        dac = ScaledOffset - (ScaledMul * v) / ScaledDiv;
      end
      default: begin
        dac = LowOffset - v;
      end
    endcase
    if (dac < 0) begin
      dac = 0;
    end else if (dac > DacCeiling) begin
      dac = DacCeiling;
    end
    duty = dac / MvPerPercent;
    cmp = (longint'(pwm_reload) * duty) / 100 + 1;
    if (cmp > CompareMax) begin
      cmp = CompareMax;
    end
    r.duty_percent = duty[6:0];
    r.compare_value = cmp[19:0];
    return r;
  endfunction

  task automatic report_mismatch(input string field, input longint unsigned got,
                                 input longint unsigned want);
    if (mismatch_count < MaxReports) begin
      $display("mismatch in %s at result %0d: got %0d, expected %0d",
               field, result_count, got, want);
    end
    mismatch_count++;
  endtask

  task automatic write_reg(input logic [rtsd_pkg::CfgIdxW-1:0] idx,
                           input logic [rtsd_pkg::CfgDataW-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      rtsd_pkg::CfgDefaultVoltage: default_voltage = data[12:0];
      rtsd_pkg::CfgDefaultPower:   default_power = data[0];
      rtsd_pkg::CfgDefaultPort:    default_port = data[0];
      rtsd_pkg::CfgBoardFormula:   formula_sel = data[1:0];
      rtsd_pkg::CfgPwmReload:      pwm_reload = data[19:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
  endtask

  // Checked at the falling edge so that every update of the rising edge has settled.
  task automatic wait_idle();
    do begin
      @(negedge clk);
    end while (pending_samples.size() != 0 || in_tvalid || expected_results.size() != 0);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_samples.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        in_tdata <= pending_samples.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      expected_results.push_back(track_sample(in_tdata));
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left <= 0;
      hold_started <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_arm && !hold_started) begin
      out_tready <= 1'b0;
      hold_left <= HoldCycles;
      hold_started <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    supply_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", out_tdata, 0);
      end else begin
        want = expected_results.pop_front();
        if (out_tdata[19:0] !== want.compare_value)
          report_mismatch("compare_value", out_tdata[19:0], want.compare_value);
        if (out_tdata[26:20] !== want.duty_percent)
          report_mismatch("duty_percent", out_tdata[26:20], want.duty_percent);
        if (out_tdata[39:27] !== want.ref_mv)
          report_mismatch("ref_mv", out_tdata[39:27], want.ref_mv);
        if (out_tdata[40] !== want.ref_present)
          report_mismatch("ref_present", out_tdata[40], want.ref_present);
        if (out_tdata[41] !== want.power_enable)
          report_mismatch("power_enable", out_tdata[41], want.power_enable);
        if (out_tdata[42] !== want.port_enable)
          report_mismatch("port_enable", out_tdata[42], want.port_enable);
        if (out_tdata[47:43] !== 5'd0)
          report_mismatch("padding", out_tdata[47:43], 0);
      end
      result_count++;
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    logic [rtsd_pkg::CfgDataW-1:0] wdata;
    int burst_left;
    int level;
    int spread;
    int s;
    int n;
    int phase;
    burst_left = 0;
    level = 0;
    spread = 0;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;

    pending_samples.push_back(16'd0);
    repeat (rtsd_pkg::AvgDepth) pending_samples.push_back(16'(AdcMax));
    repeat (rtsd_pkg::AvgDepth) pending_samples.push_back(16'(PresentAvg));
    pending_samples.push_back(16'(PresentAvg - rtsd_pkg::AvgDepth));
    wait_idle();

    write_reg(rtsd_pkg::CfgDefaultVoltage, 20'd0);
    write_reg(rtsd_pkg::CfgDefaultPower, 20'd1);
    write_reg(rtsd_pkg::CfgDefaultPort, 20'd0);
    write_reg(rtsd_pkg::CfgBoardFormula, 20'(FormulaSpare));
    write_reg(rtsd_pkg::CfgPwmReload, 20'hFFFFF);
    write_reg(rtsd_pkg::CfgPwmReload + 3'd1, 20'd7);
    pending_samples.push_back(16'(PresentAvg - rtsd_pkg::AvgDepth));
    wait_idle();

    write_reg(rtsd_pkg::CfgBoardFormula, 20'(rtsd_pkg::FormulaScaled));
    write_reg(rtsd_pkg::CfgDefaultVoltage, 20'(VoltageMax));
    write_reg(rtsd_pkg::CfgPwmReload, 20'd0);
    pending_samples.push_back(16'(PresentAvg - rtsd_pkg::AvgDepth));
    wait_idle();

    write_reg(rtsd_pkg::CfgBoardFormula, 20'(rtsd_pkg::FormulaHigh));
    write_reg(rtsd_pkg::CfgDefaultVoltage, 20'(VoltageTop));
    write_reg(rtsd_pkg::CfgDefaultPort, 20'd1);
    write_reg(rtsd_pkg::CfgPwmReload, 20'd1);
    pending_samples.push_back(16'(PresentAvg - rtsd_pkg::AvgDepth));
    wait_idle();

    for (phase = 0; phase < RandomPhases; phase++) begin
      src_idle_pct = (phase == 2) ? 0 : 15;
      sink_idle_pct = (phase == 2) ? 0 : 15;
      wdata = 20'($urandom);
      case (phase % 4)
        0: wdata[12:0] = 13'd0;
        1: wdata[12:0] = 13'(VoltageTop);
        2: wdata[12:0] = 13'(VoltageMax);
        default: wdata[12:0] = 13'($urandom_range(VoltageTop));
      endcase
      write_reg(rtsd_pkg::CfgDefaultVoltage, wdata);
      write_reg(rtsd_pkg::CfgDefaultPower, 20'($urandom));
      write_reg(rtsd_pkg::CfgDefaultPort, 20'($urandom));
      wdata = 20'($urandom);
      wdata[1:0] = 2'(phase);
      write_reg(rtsd_pkg::CfgBoardFormula, wdata);
      case (phase % 5)
        0: wdata = 20'd0;
        1: wdata = 20'd1;
        2: wdata = 20'(ReloadTop);
        3: wdata = 20'hFFFFF;
        default: wdata = 20'($urandom);
      endcase
      write_reg(rtsd_pkg::CfgPwmReload, wdata);
      if (phase % 3 == 1) begin
        write_reg(3'($urandom_range(7, rtsd_pkg::CfgPwmReload + 1)), 20'($urandom));
      end
      if (phase == 5) begin
        hold_arm = 1'b1;
      end
      for (n = 0; n < PhaseSamples; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(24, 1);
          case ($urandom_range(3))
            0: begin
              level = PresentAvg - 30 + int'($urandom_range(60));
              spread = $urandom_range(40);
            end
            1: begin
              level = $urandom_range(AdcMax);
              spread = AdcMax;
            end
            default: begin
              level = $urandom_range(AdcMax);
              spread = $urandom_range(3000);
            end
          endcase
        end
        burst_left--;
        s = level + int'($urandom_range(2 * spread)) - spread;
        if (s < 0) begin
          s = 0;
        end else if (s > AdcMax) begin
          s = AdcMax;
        end
        pending_samples.push_back(16'(s));
      end
      wait_idle();
    end

    repeat (TailCycles) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- reference_tracking_supply_duty.f -----
sv/rtsd_pkg.sv
sv/rtsd_div.sv
sv/rtsd_mul.sv
sv/reference_tracking_supply_duty.sv
dv/testbench.sv
